@@ design/pft_pkg.sv @@
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants for the pose frame transform.
// Holds the register indexes, the fixed 45-degree z rotation and the
// Q8.24 rounding helper.
// ----------------------------------------------------------------------------
package pft_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 224;
  localparam int unsigned OutDataW = 224;

  localparam logic [CfgIdxW-1:0] RegCamX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCamY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCamZ = 2'd2;

  localparam logic signed [WordW-1:0] RotzW = 32'sd15500120;
  localparam logic signed [WordW-1:0] RotzZ = 32'sd6420377;

  localparam logic OpArm  = 1'b0;
  localparam logic OpSlam = 1'b1;

  typedef logic signed [WordW:0] op_t;

  // Round a 66-bit product to Q8.24: add half an LSB, floor shift by 24.
  function automatic logic signed [41:0] fround(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p + 66'sd8388608;
    return s[65:24];
  endfunction

endpackage

@@ design/pose_frame_transform.sv @@
// ----------------------------------------------------------------------------
// pose_frame_transform
// Arm and SLAM pose events transformed through a shared multiplier.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (low bit first)
// in_      in   tdata: pos_x,pos_y,pos_z,rot_w,rot_x,rot_y,rot_z
//               tuser: opcode, is_tool_frame
// out_     out  tdata: out_pos_x..z, out_rot_w..z; tuser: path_kind
// cfg_     in   index 0..2 cam_offset_x/y/z, data 32 bits
//
// One product a cycle from one 33x33 multiplier: 48 products per kept
// event. The input word is taken in S_IDLE, decoded in S_DEC, the products
// run in S_MUL and the result is offered in S_OUT; a dropped event goes
// from S_DEC straight back to S_IDLE.
// The input is not ready while an event is in work or a result waits.
// Reset (rst_n, synchronous) clears the offsets and the reference frame.
// A stalled result holds on out_tdata until out_tready.
module pose_frame_transform (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [pft_pkg::InDataW-1:0] in_tdata,   // pos_x,pos_y,pos_z,rot_w,x,y,z
  input  logic [1:0] in_tuser,                    // opcode, is_tool_frame
  output logic out_tvalid,
  input  logic out_tready,
  output logic [pft_pkg::OutDataW-1:0] out_tdata, // pos x,y,z, rot w,x,y,z
  output logic out_tuser,                         // path_kind
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pft_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pft_pkg::WordW-1:0] cfg_data
);
  import pft_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [WordW-1:0] cam_r [3];
  logic [WordW-1:0] pos_r [3];
  logic [WordW-1:0] rot_r [4];
  logic op_r, tool_r, latched_r;
  logic [WordW-1:0] rt_r [3];
  logic [WordW-1:0] ro_r [4];
  // q: rotating quaternion, v: vector, t: q*v, u: final, o: orientation.
  logic [WordW-1:0] q_r [4];
  logic [WordW-1:0] v_r [3];
  logic [WordW-1:0] b_r [4];
  logic [WordW-1:0] t_r [4];
  logic [WordW-1:0] u_r [3];
  logic [WordW-1:0] o_r [4];
  logic [5:0] k_r;
  logic [41:0] acc_r;
  logic [WordW-1:0] res_r [7];
  logic res_op_r;

  // Step k: phase = k[5:4] (0 q*v, 1 t*conj q, 2 q*b), comp k[3:2], term k[1:0].
  logic [1:0] ph, comp, term, ai, bi;
  logic neg, negc;
  op_t a_op, b_op;
  logic signed [65:0] prod;
  logic signed [41:0] rnd, acc_sum;

  always_comb begin
    ph = k_r[5:4];
    comp = k_r[3:2];
    term = k_r[1:0];
    ai = term;
    // Hamilton product: r[c] = sum over i of sign * a[i] * b[i ^ c].
    bi = term ^ comp;
    unique case (comp)
      2'd0: neg = (term != 2'd0);
      2'd1: neg = (term == 2'd3);
      2'd2: neg = (term == 2'd1);
      default: neg = (term == 2'd2);
    endcase
    a_op = 33'sd0;
    b_op = 33'sd0;
    negc = 1'b0;
    unique case (ph)
      2'd0: begin
        a_op = {q_r[ai][WordW-1], q_r[ai]};
        b_op = (bi == 2'd0) ? 33'sd0 : {v_r[bi-2'd1][WordW-1], v_r[bi-2'd1]};
      end
      2'd1: begin
        a_op = {t_r[ai][WordW-1], t_r[ai]};
        b_op = {q_r[bi][WordW-1], q_r[bi]};
        negc = (bi != 2'd0);
      end
      default: begin
        a_op = {q_r[ai][WordW-1], q_r[ai]};
        b_op = {b_r[bi][WordW-1], b_r[bi]};
      end
    endcase
    if (negc) b_op = -b_op;
    prod = a_op * b_op;
    rnd = fround(prod);
    acc_sum = (term == 2'd0) ? 42'sd0 : $signed(acc_r);
    acc_sum = neg ? acc_sum - rnd : acc_sum + rnd;
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser = res_op_r;
  always_comb begin
    for (int i = 0; i < 7; i++) out_tdata[i*WordW +: WordW] = res_r[i];
  end

  logic keep;
  always_comb begin
    if (op_r == OpArm) keep = tool_r && !((pos_r[2] == '0) && !latched_r);
    else keep = latched_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_DEC;
      S_DEC: state_nxt = keep ? S_MUL : S_IDLE;
      S_MUL: if (k_r == 6'd47) state_nxt = S_OUT;
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      latched_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cam_r[i] <= '0;
        rt_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) ro_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegCamX: cam_r[0] <= cfg_data;
          RegCamY: cam_r[1] <= cfg_data;
          RegCamZ: cam_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_MUL && k_r == 6'd47 && op_r == OpArm && !latched_r) begin
        latched_r <= 1'b1;
        for (int i = 0; i < 3; i++) rt_r[i] <= WordW'(pos_r[i] + u_r[i]);
        for (int i = 0; i < 3; i++) ro_r[i] <= o_r[i];
        ro_r[3] <= acc_sum[WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      op_r <= in_tuser[0];
      tool_r <= in_tuser[1];
      for (int i = 0; i < 3; i++) pos_r[i] <= in_tdata[i*WordW +: WordW];
      for (int i = 0; i < 4; i++) rot_r[i] <= in_tdata[(i+3)*WordW +: WordW];
    end
    if (state_r == S_DEC) begin
      k_r <= '0;
      if (op_r == OpArm) begin
        q_r <= rot_r;
        v_r <= cam_r;
        b_r[0] <= RotzW; b_r[1] <= '0; b_r[2] <= '0; b_r[3] <= RotzZ;
      end else begin
        q_r <= ro_r;
        v_r <= pos_r;
        b_r <= rot_r;
        pos_r <= rt_r;
      end
    end
    if (state_r == S_MUL) begin
      k_r <= k_r + 6'd1;
      acc_r <= acc_sum;
      if (term == 2'd3) begin
        unique case (ph)
          2'd0: t_r[comp] <= acc_sum[WordW-1:0];
          2'd1: if (comp != 2'd0) u_r[comp-2'd1] <= acc_sum[WordW-1:0];
          default: o_r[comp] <= acc_sum[WordW-1:0];
        endcase
      end
      if (k_r == 6'd47) begin
        res_op_r <= op_r;
        for (int i = 0; i < 3; i++) res_r[i] <= WordW'(pos_r[i] + u_r[i]);
        for (int i = 0; i < 3; i++) res_r[i+3] <= o_r[i];
        res_r[6] <= acc_sum[WordW-1:0];
      end
    end
  end

  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accepting while busy");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    latched_r |=> latched_r) else $error("reference lost");

endmodule
